[rtl/core/fre_pkg.sv]
package fre_pkg;

   localparam int STORE_BYTES     = 8192;
   localparam int ADDR_W          = $clog2(STORE_BYTES);
   localparam int FILL_W          = ADDR_W + 1;
   localparam int FRAG_SLOTS      = 16;
   localparam int SLOT_W          = (FRAG_SLOTS > 2) ? $clog2(FRAG_SLOTS) : 1;
   localparam int BR_W            = 17;
   localparam int NUM_W           = 8;
   localparam int HDR_BYTES       = 8;
   localparam int LEN_OFF         = 24;
   localparam int LEN_OFF_NATT    = 28;
   localparam int LEN_FIELD_BYTES = 4;
   localparam int NATT_PREFIX     = 4;
   localparam int CSR_AW          = 4;

   localparam logic [7:0]         TIMEOUT_RESET = 8'd70;
   localparam logic [7:0]         TIMER_MAX     = 8'hFF;
   localparam logic [NUM_W-1:0]   NUM_MAX       = '1;

   localparam logic [1:0] REG_FRAG_ENABLED    = 2'd0;
   localparam logic [1:0] REG_NATT_MODE       = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_SECONDS = 2'd2;

   typedef enum logic [2:0] {
      KIND_HDR   = 3'd0,
      KIND_BYTE  = 3'd1,
      KIND_TICK  = 3'd2,
      KIND_FLUSH = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      RES_WAIT    = 4'd0,
      RES_DONE    = 4'd1,
      RES_DUP     = 4'd2,
      RES_BAD     = 4'd3,
      RES_OFF     = 4'd4,
      RES_FAIL    = 4'd5,
      RES_FULL    = 4'd6,
      RES_FLUSHED = 4'd7,
      RES_BYTE    = 4'd8,
      RES_NONE    = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      SL_FREE = 2'd0,
      SL_RECV = 2'd1,
      SL_HELD = 2'd2,
      SL_READ = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RX_IDLE  = 2'd0,
      RX_STORE = 2'd1,
      RX_SKIP  = 2'd2
   } rx_mode_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_HDR,
      OP_HSCAN,
      OP_HALLOC,
      OP_BYTE,
      OP_TICK,
      OP_FLUSH,
      OP_TC_INIT,
      OP_TC_SCAN,
      OP_CHK_RD,
      OP_CHK_ACC,
      OP_TC_OK,
      OP_TC_FAIL,
      OP_RD_SCAN,
      OP_RD_ISSUE,
      OP_RD_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_HSCAN,
      ST_HALLOC,
      ST_TC_INIT,
      ST_TC_SCAN,
      ST_CHK_RD,
      ST_CHK_ACC,
      ST_CHK_CMP,
      ST_RD_SCAN,
      ST_RD_ISSUE,
      ST_RD_OUT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       en;
      logic       natt;
      logic [7:0] tout;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic       res_load;
      status_type res_code;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     en;
      logic     hlen_short;
      logic     scan_end;
      logic     hdr_dup;
      logic     alloc_ok;
      logic     plen_zero;
      logic     byte_done;
      logic     tick_flush;
      logic     tc_match;
      logic     tc_last;
      logic     n_max;
      logic     chk_short;
      logic     k_end;
      logic     dw_ok;
      logic     left_zero;
      logic     rd_hit;
      logic     rd_match;
   } flag_type;

endpackage

[rtl/core/fragment_reassembly_engine_unit.sv]
// Reassembles fragmented key-exchange messages. Each fragment is one header word and then one
// word per payload byte; every input word returns exactly one result word. Fragments sit in a
// table of FRAG_SLOTS slots that a single scan counter walks one slot per cycle, with payload in
// an 8 KiB byte store with one read and one write port. An accepted header first scans every
// slot for a duplicate and a free slot, then allocates. A fragment whose payload is complete
// starts a completeness walk that searches the slots for each fragment number in turn, then
// reads the length field byte by byte and compares it with the total. A read-out word scans the
// slots for the next fragment when it starts one, then reads the byte store. The result
// register lets the next word be accepted while the previous result waits.
module fragment_reassembly_engine_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_kind,
   input  logic [15:0]                 req_frag_id,
   input  logic [7:0]                  req_frag_num,
   input  logic                        req_last_fragment,
   input  logic [15:0]                 req_hdr_length,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [3:0]                  rsp_status,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_out_last,
   output logic [13:0]                 rsp_message_length,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fre_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic       en_ff,   en_in;
   logic       natt_ff, natt_in;
   logic [7:0] tout_ff, tout_in;
   logic       csr_wr;

   fre_pkg::cfg_type  cfg;
   fre_pkg::cmd_type  cmd;
   fre_pkg::flag_type flag;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      en_in   = en_ff;
      natt_in = natt_ff;
      tout_in = tout_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            fre_pkg::REG_FRAG_ENABLED:    en_in   = pwdata[0];
            fre_pkg::REG_NATT_MODE:       natt_in = pwdata[0];
            fre_pkg::REG_TIMEOUT_SECONDS: tout_in = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b1;
         natt_ff <= 1'b0;
         tout_ff <= fre_pkg::TIMEOUT_RESET;
      end else begin
         en_ff   <= en_in;
         natt_ff <= natt_in;
         tout_ff <= tout_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         fre_pkg::REG_FRAG_ENABLED:    prdata = {31'd0, en_ff};
         fre_pkg::REG_NATT_MODE:       prdata = {31'd0, natt_ff};
         fre_pkg::REG_TIMEOUT_SECONDS: prdata = {24'd0, tout_ff};
         default:                      prdata = '0;
      endcase
   end

   assign cfg.en   = en_ff;
   assign cfg.natt = natt_ff;
   assign cfg.tout = tout_ff;

   fre_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flag      (flag),
      .cmd       (cmd)
   );

   fre_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .flag               (flag),
      .req_kind           (req_kind),
      .req_frag_id        (req_frag_id),
      .req_frag_num       (req_frag_num),
      .req_last_fragment  (req_last_fragment),
      .req_hdr_length     (req_hdr_length),
      .req_data_byte      (req_data_byte),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last),
      .rsp_message_length (rsp_message_length)
   );

endmodule

[rtl/core/fre_datapath.sv]
module fre_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  fre_pkg::cfg_type       cfg,
   input  fre_pkg::cmd_type       cmd,
   output fre_pkg::flag_type      flag,
   input  logic [2:0]             req_kind,
   input  logic [15:0]            req_frag_id,
   input  logic [7:0]             req_frag_num,
   input  logic                   req_last_fragment,
   input  logic [15:0]            req_hdr_length,
   input  logic [7:0]             req_data_byte,
   output logic [3:0]             rsp_status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last,
   output logic [13:0]            rsp_message_length
);

   localparam int NS = fre_pkg::FRAG_SLOTS;
   localparam int AW = fre_pkg::ADDR_W;
   localparam int FW = fre_pkg::FILL_W;
   localparam int SW = fre_pkg::SLOT_W;
   localparam int BW = fre_pkg::BR_W;
   localparam int NW = fre_pkg::NUM_W;

   // input word
   logic [2:0]  kind_ff,  kind_in;
   logic [15:0] id_ff,    id_in;
   logic [7:0]  num_ff,   num_in;
   logic        lastf_ff, lastf_in;
   logic [15:0] hlen_ff,  hlen_in;
   logic [7:0]  db_ff,    db_in;

   // slot table
   fre_pkg::slot_state_type sl_st_ff [NS];
   fre_pkg::slot_state_type sl_st_in [NS];
   logic [15:0]   sl_id_ff    [NS];
   logic [15:0]   sl_id_in    [NS];
   logic [NW-1:0] sl_num_ff   [NS];
   logic [NW-1:0] sl_num_in   [NS];
   logic          sl_last_ff  [NS];
   logic          sl_last_in  [NS];
   logic [AW-1:0] sl_start_ff [NS];
   logic [AW-1:0] sl_start_in [NS];
   logic [FW-1:0] sl_len_ff   [NS];
   logic [FW-1:0] sl_len_in   [NS];
   logic [NW-1:0] sl_seq_ff   [NS];
   logic [NW-1:0] sl_seq_in   [NS];
   logic [NS-1:0] member_ff, member_in;

   fre_pkg::rx_mode_type rx_mode_ff, rx_mode_in;
   logic [FW-1:0] fill_ff,     fill_in;
   logic [BW-1:0] br_ff,       br_in;
   logic [SW-1:0] rx_slot_ff,  rx_slot_in;
   logic [AW-1:0] rx_start_ff, rx_start_in;
   logic [AW-1:0] wr_addr_ff,  wr_addr_in;
   logic          active_ff,   active_in;
   logic [7:0]    timer_ff,    timer_in;
   logic [15:0]   key_id_ff,   key_id_in;
   logic [BW-1:0] plen_ff,     plen_in;
   logic [SW-1:0] scan_ff,     scan_in;
   logic          dup_ff,      dup_in;
   logic          free_ok_ff,  free_ok_in;
   logic [SW-1:0] free_idx_ff, free_idx_in;
   logic [NW-1:0] n_ff,        n_in;
   logic [NW-1:0] seq_ff,      seq_in;
   logic [FW-1:0] total_ff,    total_in;
   logic [AW-1:0] f1_start_ff, f1_start_in;
   logic [FW-1:0] f1_len_ff,   f1_len_in;
   logic [1:0]    k_ff,        k_in;
   logic [31:0]   dw_ff,       dw_in;
   logic [FW-1:0] left_ff,     left_in;
   logic [FW-1:0] cursor_ff,   cursor_in;
   logic [NW-1:0] rslot_ff,    rslot_in;
   logic          rd_hit_ff,   rd_hit_in;
   logic [SW-1:0] rd_idx_ff,   rd_idx_in;
   logic [AW-1:0] rd_start_ff, rd_start_in;
   logic [FW-1:0] rd_len_ff,   rd_len_in;
   logic [7:0]    stg_byte_ff, stg_byte_in;
   logic          stg_last_ff, stg_last_in;
   logic [FW-1:0] stg_mlen_ff, stg_mlen_in;
   logic [3:0]    out_status_ff;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic [13:0]   out_mlen_ff;

   // byte store
   logic [7:0]    byte_mem [fre_pkg::STORE_BYTES];
   logic [7:0]    mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic          any_used;
   logic [FW-1:0] fill_eff;
   logic [BW:0]   room_sum;
   logic          room;
   fre_pkg::slot_state_type cst;
   logic [15:0]   cid;
   logic [NW-1:0] cnum;
   logic          clast;
   logic [AW-1:0] cstart;
   logic [FW-1:0] clen;
   logic          scan_end;
   logic [SW-1:0] scan_nx;
   logic          free_here;
   logic          dup_here;
   logic          tc_match;
   logic          rd_match;
   logic [FW-1:0] chk_off;
   logic          chk_short;
   logic [AW-1:0] chk_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   dw_adj;
   logic [7:0]    tnew;
   logic          tick_flush;
   logic          alloc_ok;
   logic [FW-1:0] cursor_nx;

   always_comb begin
      any_used = 1'b0;
      for (int i = 0; i < NS; i++) begin
         if (sl_st_ff[i] != fre_pkg::SL_FREE) begin
            any_used = 1'b1;
         end
      end
   end

   assign fill_eff  = any_used ? fill_ff : '0;
   assign room_sum  = (BW+1)'(fill_eff) + (BW+1)'(plen_ff);
   assign room      = room_sum <= (BW+1)'(fre_pkg::STORE_BYTES);
   assign cst       = sl_st_ff[scan_ff];
   assign cid       = sl_id_ff[scan_ff];
   assign cnum      = sl_num_ff[scan_ff];
   assign clast     = sl_last_ff[scan_ff];
   assign cstart    = sl_start_ff[scan_ff];
   assign clen      = sl_len_ff[scan_ff];
   assign scan_end  = scan_ff == SW'(NS - 1);
   assign scan_nx   = scan_end ? '0 : scan_ff + SW'(1);
   assign free_here = cst == fre_pkg::SL_FREE;
   assign dup_here  = (cst == fre_pkg::SL_HELD) && (cid == id_ff) && (cnum == num_ff);
   assign tc_match  = (cst == fre_pkg::SL_HELD) && (cid == key_id_ff) && (cnum == n_ff);
   assign rd_match  = (cst == fre_pkg::SL_READ) && (cnum == rslot_ff);
   assign chk_off   = cfg.natt ? FW'(fre_pkg::LEN_OFF_NATT) : FW'(fre_pkg::LEN_OFF);
   assign chk_short = f1_len_ff < (chk_off + FW'(fre_pkg::LEN_FIELD_BYTES));
   assign chk_addr  = f1_start_ff + chk_off[AW-1:0] + AW'(k_ff);
   assign rd_addr   = rd_start_ff + cursor_ff[AW-1:0];
   assign mem_raddr = (cmd.op == fre_pkg::OP_CHK_RD) ? chk_addr : rd_addr;
   assign dw_adj    = dw_ff + (cfg.natt ? 32'(fre_pkg::NATT_PREFIX) : 32'd0);
   assign tnew      = (timer_ff == fre_pkg::TIMER_MAX) ? timer_ff : timer_ff + 8'd1;
   assign tick_flush = active_ff && (tnew >= cfg.tout);
   assign alloc_ok  = !dup_ff && free_ok_ff && room;
   assign cursor_nx = cursor_ff + FW'(1);

   always_comb begin
      flag.kind       = fre_pkg::kind_type'(kind_ff);
      flag.en         = cfg.en;
      flag.hlen_short = hlen_ff < 16'(fre_pkg::HDR_BYTES);
      flag.scan_end   = scan_end;
      flag.hdr_dup    = dup_ff;
      flag.alloc_ok   = alloc_ok;
      flag.plen_zero  = plen_ff == '0;
      flag.byte_done  = (rx_mode_ff == fre_pkg::RX_STORE) && (br_ff == BW'(1));
      flag.tick_flush = tick_flush;
      flag.tc_match   = tc_match;
      flag.tc_last    = clast;
      flag.n_max      = n_ff == fre_pkg::NUM_MAX;
      flag.chk_short  = chk_short;
      flag.k_end      = k_ff == 2'd3;
      flag.dw_ok      = dw_adj == 32'(total_ff);
      flag.left_zero  = left_ff == '0;
      flag.rd_hit     = rd_hit_ff;
      flag.rd_match   = rd_match;
   end

   always_comb begin
      kind_in     = kind_ff;
      id_in       = id_ff;
      num_in      = num_ff;
      lastf_in    = lastf_ff;
      hlen_in     = hlen_ff;
      db_in       = db_ff;
      sl_st_in    = sl_st_ff;
      sl_id_in    = sl_id_ff;
      sl_num_in   = sl_num_ff;
      sl_last_in  = sl_last_ff;
      sl_start_in = sl_start_ff;
      sl_len_in   = sl_len_ff;
      sl_seq_in   = sl_seq_ff;
      member_in   = member_ff;
      rx_mode_in  = rx_mode_ff;
      fill_in     = fill_ff;
      br_in       = br_ff;
      rx_slot_in  = rx_slot_ff;
      rx_start_in = rx_start_ff;
      wr_addr_in  = wr_addr_ff;
      active_in   = active_ff;
      timer_in    = timer_ff;
      key_id_in   = key_id_ff;
      plen_in     = plen_ff;
      scan_in     = scan_ff;
      dup_in      = dup_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      n_in        = n_ff;
      seq_in      = seq_ff;
      total_in    = total_ff;
      f1_start_in = f1_start_ff;
      f1_len_in   = f1_len_ff;
      k_in        = k_ff;
      dw_in       = dw_ff;
      left_in     = left_ff;
      cursor_in   = cursor_ff;
      rslot_in    = rslot_ff;
      rd_hit_in   = rd_hit_ff;
      rd_idx_in   = rd_idx_ff;
      rd_start_in = rd_start_ff;
      rd_len_in   = rd_len_ff;
      stg_byte_in = stg_byte_ff;
      stg_last_in = stg_last_ff;
      stg_mlen_in = stg_mlen_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_addr_ff;

      case (cmd.op)
         fre_pkg::OP_LOAD: begin
            kind_in     = req_kind;
            id_in       = req_frag_id;
            num_in      = req_frag_num;
            lastf_in    = req_last_fragment;
            hlen_in     = req_hdr_length;
            db_in       = req_data_byte;
            scan_in     = '0;
            stg_byte_in = '0;
            stg_last_in = 1'b0;
            stg_mlen_in = '0;
         end
         fre_pkg::OP_HDR, fre_pkg::OP_FLUSH, fre_pkg::OP_TICK: begin
            if ((cmd.op != fre_pkg::OP_TICK) || tick_flush) begin
               // drop the fragment being received
               if (rx_mode_ff == fre_pkg::RX_STORE) begin
                  fill_in              = FW'(rx_start_ff);
                  sl_st_in[rx_slot_ff] = fre_pkg::SL_FREE;
               end
               rx_mode_in = fre_pkg::RX_IDLE;
               br_in      = '0;
            end
            if (cmd.op == fre_pkg::OP_HDR) begin
               if (cfg.en && !active_ff) begin
                  active_in = 1'b1;
                  timer_in  = '0;
                  for (int i = 0; i < NS; i++) begin
                     if (sl_st_ff[i] == fre_pkg::SL_HELD) begin
                        sl_st_in[i] = fre_pkg::SL_FREE;
                     end
                  end
               end
               plen_in = BW'(hlen_ff) - BW'(fre_pkg::HDR_BYTES)
                       + ((cfg.natt && (num_ff == 8'd1)) ? BW'(fre_pkg::NATT_PREFIX) : '0);
               dup_in     = 1'b0;
               free_ok_in = 1'b0;
            end else if ((cmd.op == fre_pkg::OP_FLUSH) || tick_flush) begin
               for (int i = 0; i < NS; i++) begin
                  if (sl_st_ff[i] == fre_pkg::SL_HELD) begin
                     sl_st_in[i] = fre_pkg::SL_FREE;
                  end
               end
               active_in = 1'b0;
               timer_in  = '0;
            end else if (active_ff) begin
               timer_in = tnew;
            end
         end
         fre_pkg::OP_HSCAN: begin
            if (free_here && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = scan_ff;
            end
            if (dup_here) begin
               dup_in = 1'b1;
            end
            scan_in = scan_nx;
         end
         fre_pkg::OP_HALLOC: begin
            if (alloc_ok) begin
               sl_st_in[free_idx_ff]    = (plen_ff == '0) ? fre_pkg::SL_HELD : fre_pkg::SL_RECV;
               sl_id_in[free_idx_ff]    = id_ff;
               sl_num_in[free_idx_ff]   = num_ff;
               sl_last_in[free_idx_ff]  = lastf_ff;
               sl_start_in[free_idx_ff] = fill_eff[AW-1:0];
               sl_len_in[free_idx_ff]   = plen_ff[FW-1:0];
               fill_in                  = room_sum[FW-1:0];
               key_id_in                = id_ff;
               if (plen_ff != '0) begin
                  rx_mode_in  = fre_pkg::RX_STORE;
                  rx_slot_in  = free_idx_ff;
                  br_in       = plen_ff;
                  wr_addr_in  = fill_eff[AW-1:0];
                  rx_start_in = fill_eff[AW-1:0];
               end
            end else if (plen_ff != '0) begin
               rx_mode_in = fre_pkg::RX_SKIP;
               br_in      = plen_ff;
            end
         end
         fre_pkg::OP_BYTE: begin
            if (rx_mode_ff == fre_pkg::RX_STORE) begin
               mem_we     = 1'b1;
               wr_addr_in = wr_addr_ff + AW'(1);
               br_in      = br_ff - BW'(1);
               if (br_ff == BW'(1)) begin
                  rx_mode_in           = fre_pkg::RX_IDLE;
                  sl_st_in[rx_slot_ff] = fre_pkg::SL_HELD;
               end
            end else if (rx_mode_ff == fre_pkg::RX_SKIP) begin
               br_in = br_ff - BW'(1);
               if (br_ff == BW'(1)) begin
                  rx_mode_in = fre_pkg::RX_IDLE;
               end
            end
         end
         fre_pkg::OP_TC_INIT: begin
            n_in      = NW'(1);
            seq_in    = '0;
            total_in  = '0;
            member_in = '0;
            scan_in   = '0;
            k_in      = '0;
         end
         fre_pkg::OP_TC_SCAN: begin
            if (tc_match) begin
               member_in[scan_ff] = 1'b1;
               total_in           = total_ff + clen;
               sl_seq_in[scan_ff] = seq_ff;
               if (clen != '0) begin
                  seq_in = seq_ff + NW'(1);
               end
               if (n_ff == NW'(1)) begin
                  f1_start_in = cstart;
                  f1_len_in   = clen;
               end
               n_in    = n_ff + NW'(1);
               scan_in = '0;
            end else begin
               scan_in = scan_nx;
            end
         end
         fre_pkg::OP_CHK_ACC: begin
            dw_in = {dw_ff[23:0], mem_q_ff};
            k_in  = k_ff + 2'd1;
         end
         fre_pkg::OP_TC_OK: begin
            for (int i = 0; i < NS; i++) begin
               if (member_ff[i]) begin
                  sl_st_in[i]  = (sl_len_ff[i] == '0) ? fre_pkg::SL_FREE : fre_pkg::SL_READ;
                  sl_num_in[i] = sl_seq_ff[i];
               end else if (sl_st_ff[i] == fre_pkg::SL_READ) begin
                  sl_st_in[i] = fre_pkg::SL_FREE;
               end
            end
            rslot_in    = '0;
            cursor_in   = '0;
            left_in     = total_ff;
            active_in   = 1'b0;
            timer_in    = '0;
            rd_hit_in   = 1'b0;
            stg_mlen_in = total_ff;
         end
         fre_pkg::OP_TC_FAIL: begin
            for (int i = 0; i < NS; i++) begin
               if (member_ff[i]) begin
                  sl_st_in[i] = fre_pkg::SL_FREE;
               end
            end
         end
         fre_pkg::OP_RD_SCAN: begin
            if (rd_match) begin
               rd_hit_in   = 1'b1;
               rd_idx_in   = scan_ff;
               rd_start_in = cstart;
               rd_len_in   = clen;
            end else if (scan_end) begin
               left_in = '0;
               for (int i = 0; i < NS; i++) begin
                  if (sl_st_ff[i] == fre_pkg::SL_READ) begin
                     sl_st_in[i] = fre_pkg::SL_FREE;
                  end
               end
            end
            scan_in = scan_nx;
         end
         fre_pkg::OP_RD_OUT: begin
            stg_byte_in = mem_q_ff;
            cursor_in   = cursor_nx;
            left_in     = left_ff - FW'(1);
            if (cursor_nx >= rd_len_ff) begin
               sl_st_in[rd_idx_ff] = fre_pkg::SL_FREE;
               rslot_in            = rslot_ff + NW'(1);
               cursor_in           = '0;
               rd_hit_in           = 1'b0;
            end
            if (left_ff == FW'(1)) begin
               stg_last_in = 1'b1;
               for (int i = 0; i < NS; i++) begin
                  if (sl_st_ff[i] == fre_pkg::SL_READ) begin
                     sl_st_in[i] = fre_pkg::SL_FREE;
                  end
               end
               rslot_in  = '0;
               cursor_in = '0;
               rd_hit_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            sl_st_ff[i] <= fre_pkg::SL_FREE;
         end
         rx_mode_ff <= fre_pkg::RX_IDLE;
         fill_ff    <= '0;
         br_ff      <= '0;
         active_ff  <= 1'b0;
         timer_ff   <= '0;
         scan_ff    <= '0;
         left_ff    <= '0;
         cursor_ff  <= '0;
         rslot_ff   <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         sl_st_ff   <= sl_st_in;
         rx_mode_ff <= rx_mode_in;
         fill_ff    <= fill_in;
         br_ff      <= br_in;
         active_ff  <= active_in;
         timer_ff   <= timer_in;
         scan_ff    <= scan_in;
         left_ff    <= left_in;
         cursor_ff  <= cursor_in;
         rslot_ff   <= rslot_in;
         rd_hit_ff  <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      num_ff      <= num_in;
      lastf_ff    <= lastf_in;
      hlen_ff     <= hlen_in;
      db_ff       <= db_in;
      sl_id_ff    <= sl_id_in;
      sl_num_ff   <= sl_num_in;
      sl_last_ff  <= sl_last_in;
      sl_start_ff <= sl_start_in;
      sl_len_ff   <= sl_len_in;
      sl_seq_ff   <= sl_seq_in;
      member_ff   <= member_in;
      rx_slot_ff  <= rx_slot_in;
      rx_start_ff <= rx_start_in;
      wr_addr_ff  <= wr_addr_in;
      key_id_ff   <= key_id_in;
      plen_ff     <= plen_in;
      dup_ff      <= dup_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      n_ff        <= n_in;
      seq_ff      <= seq_in;
      total_ff    <= total_in;
      f1_start_ff <= f1_start_in;
      f1_len_ff   <= f1_len_in;
      k_ff        <= k_in;
      dw_ff       <= dw_in;
      rd_idx_ff   <= rd_idx_in;
      rd_start_ff <= rd_start_in;
      rd_len_ff   <= rd_len_in;
      stg_byte_ff <= stg_byte_in;
      stg_last_ff <= stg_last_in;
      stg_mlen_ff <= stg_mlen_in;
      if (cmd.res_load) begin
         out_status_ff <= cmd.res_code;
         out_byte_ff   <= stg_byte_ff;
         out_last_ff   <= stg_last_ff;
         out_mlen_ff   <= 14'(stg_mlen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem[mem_waddr] <= db_ff;
      end
      mem_q_ff <= byte_mem[mem_raddr];
   end

   assign rsp_status         = out_status_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_out_last       = out_last_ff;
   assign rsp_message_length = out_mlen_ff;

endmodule

[rtl/core/fre_control.sv]
module fre_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  fre_pkg::flag_type   flag,
   output fre_pkg::cmd_type    cmd
);

   fre_pkg::ctrl_state_type state_ff, state_in;
   fre_pkg::status_type     code_ff,  code_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fre_pkg::ST_IDLE;
         code_ff      <= fre_pkg::RES_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      req_ready    = 1'b0;
      cmd.op       = fre_pkg::OP_NONE;
      cmd.res_load = 1'b0;
      cmd.res_code = code_ff;

      case (state_ff)
         fre_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = fre_pkg::OP_LOAD;
               state_in = fre_pkg::ST_DISPATCH;
            end
         end
         fre_pkg::ST_DISPATCH: begin
            state_in = fre_pkg::ST_DONE;
            code_in  = fre_pkg::RES_NONE;
            case (flag.kind)
               fre_pkg::KIND_HDR: begin
                  cmd.op = fre_pkg::OP_HDR;
                  if (!flag.en) begin
                     code_in = fre_pkg::RES_OFF;
                  end else if (flag.hlen_short) begin
                     code_in = fre_pkg::RES_BAD;
                  end else begin
                     state_in = fre_pkg::ST_HSCAN;
                  end
               end
               fre_pkg::KIND_BYTE: begin
                  cmd.op = fre_pkg::OP_BYTE;
                  if (flag.byte_done) begin
                     state_in = fre_pkg::ST_TC_INIT;
                  end
               end
               fre_pkg::KIND_TICK: begin
                  cmd.op = fre_pkg::OP_TICK;
                  if (flag.tick_flush) begin
                     code_in = fre_pkg::RES_FLUSHED;
                  end
               end
               fre_pkg::KIND_FLUSH: begin
                  cmd.op  = fre_pkg::OP_FLUSH;
                  code_in = fre_pkg::RES_FLUSHED;
               end
               fre_pkg::KIND_READ: begin
                  if (!flag.left_zero) begin
                     state_in = flag.rd_hit ? fre_pkg::ST_RD_ISSUE : fre_pkg::ST_RD_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         fre_pkg::ST_HSCAN: begin
            cmd.op = fre_pkg::OP_HSCAN;
            if (flag.scan_end) begin
               state_in = fre_pkg::ST_HALLOC;
            end
         end
         fre_pkg::ST_HALLOC: begin
            cmd.op   = fre_pkg::OP_HALLOC;
            state_in = fre_pkg::ST_DONE;
            if (flag.hdr_dup) begin
               code_in = fre_pkg::RES_DUP;
            end else if (!flag.alloc_ok) begin
               code_in = fre_pkg::RES_FULL;
            end else if (flag.plen_zero) begin
               state_in = fre_pkg::ST_TC_INIT;
            end else begin
               code_in = fre_pkg::RES_WAIT;
            end
         end
         fre_pkg::ST_TC_INIT: begin
            cmd.op   = fre_pkg::OP_TC_INIT;
            state_in = fre_pkg::ST_TC_SCAN;
         end
         fre_pkg::ST_TC_SCAN: begin
            cmd.op = fre_pkg::OP_TC_SCAN;
            if (flag.tc_match) begin
               if (flag.tc_last) begin
                  state_in = fre_pkg::ST_CHK_RD;
               end else if (flag.n_max) begin
                  code_in  = fre_pkg::RES_WAIT;
                  state_in = fre_pkg::ST_DONE;
               end
            end else if (flag.scan_end) begin
               code_in  = fre_pkg::RES_WAIT;
               state_in = fre_pkg::ST_DONE;
            end
         end
         fre_pkg::ST_CHK_RD: begin
            if (flag.chk_short) begin
               cmd.op   = fre_pkg::OP_TC_FAIL;
               code_in  = fre_pkg::RES_FAIL;
               state_in = fre_pkg::ST_DONE;
            end else begin
               cmd.op   = fre_pkg::OP_CHK_RD;
               state_in = fre_pkg::ST_CHK_ACC;
            end
         end
         fre_pkg::ST_CHK_ACC: begin
            cmd.op   = fre_pkg::OP_CHK_ACC;
            state_in = flag.k_end ? fre_pkg::ST_CHK_CMP : fre_pkg::ST_CHK_RD;
         end
         fre_pkg::ST_CHK_CMP: begin
            state_in = fre_pkg::ST_DONE;
            if (flag.dw_ok) begin
               cmd.op  = fre_pkg::OP_TC_OK;
               code_in = fre_pkg::RES_DONE;
            end else begin
               cmd.op  = fre_pkg::OP_TC_FAIL;
               code_in = fre_pkg::RES_FAIL;
            end
         end
         fre_pkg::ST_RD_SCAN: begin
            cmd.op = fre_pkg::OP_RD_SCAN;
            if (flag.rd_match) begin
               state_in = fre_pkg::ST_RD_ISSUE;
            end else if (flag.scan_end) begin
               code_in  = fre_pkg::RES_NONE;
               state_in = fre_pkg::ST_DONE;
            end
         end
         fre_pkg::ST_RD_ISSUE: begin
            cmd.op   = fre_pkg::OP_RD_ISSUE;
            state_in = fre_pkg::ST_RD_OUT;
         end
         fre_pkg::ST_RD_OUT: begin
            cmd.op   = fre_pkg::OP_RD_OUT;
            code_in  = fre_pkg::RES_BYTE;
            state_in = fre_pkg::ST_DONE;
         end
         fre_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               state_in     = fre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fre_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[bench/fragment_reassembly_engine_unit_tb.sv]
module fragment_reassembly_engine_unit_tb;
   import fre_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 3000000;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [7:0]  num;
      logic        last;
      logic [15:0] hlen;
      logic [7:0]  db;
   } word_t;

   typedef struct {
      status_type  status;
      logic [7:0]  out_byte;
      logic        out_last;
      logic [13:0] msg_len;
   } result_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic [15:0] req_frag_id = '0;
   logic [7:0] req_frag_num = '0;
   logic req_last_fragment = 0;
   logic [15:0] req_hdr_length = '0;
   logic [7:0] req_data_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [3:0] rsp_status;
   logic [7:0] rsp_out_byte;
   logic rsp_out_last;
   logic [13:0] rsp_message_length;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   fragment_reassembly_engine_unit u_dut (.*);

   always #1 clock = ~clock;

   word_t   pending[$];
   result_t expected_results[$];
   int errors = 0;
   int checked = 0;
   int completions = 0;
   int words_queued = 0;
   int cycles = 0;

   // ---------------- reassembly predictor ----------------
   bit             cfg_en;
   bit             cfg_natt;
   int             cfg_tout;
   logic [7:0]     store_mem[STORE_BYTES];
   slot_state_type sl_st[FRAG_SLOTS];
   logic [15:0]    sl_id[FRAG_SLOTS];
   int             sl_num[FRAG_SLOTS];
   bit             sl_last[FRAG_SLOTS];
   int             sl_start[FRAG_SLOTS];
   int             sl_len[FRAG_SLOTS];
   int             fill_ptr, remain, timer_cnt, rd_cursor, rd_slot, rd_left, rx_slot;
   bit             active;
   rx_mode_type    rx_mode;

   function automatic void model_reset();
      cfg_en = 1; cfg_natt = 0; cfg_tout = 70;
      for (int i = 0; i < STORE_BYTES; i++) store_mem[i] = 0;
      for (int i = 0; i < FRAG_SLOTS; i++) begin
         sl_st[i] = SL_FREE; sl_id[i] = 0; sl_num[i] = 0;
         sl_last[i] = 0; sl_start[i] = 0; sl_len[i] = 0;
      end
      fill_ptr = 0; remain = 0; active = 0; timer_cnt = 0;
      rd_cursor = 0; rd_slot = 0; rd_left = 0; rx_mode = RX_IDLE; rx_slot = 0;
   endfunction

   function automatic void rewind_if_empty();
      for (int i = 0; i < FRAG_SLOTS; i++)
         if (sl_st[i] != SL_FREE) return;
      fill_ptr = 0;
   endfunction

   function automatic void free_state(slot_state_type s);
      for (int i = 0; i < FRAG_SLOTS; i++)
         if (sl_st[i] == s) sl_st[i] = SL_FREE;
   endfunction

   function automatic void drop_receiving();
      if (rx_mode == RX_STORE) begin
         fill_ptr = sl_start[rx_slot];
         sl_st[rx_slot] = SL_FREE;
      end
      rx_mode = RX_IDLE;
      remain = 0;
      rewind_if_empty();
   endfunction

   function automatic void flush_fragments();
      drop_receiving();
      free_state(SL_HELD);
      active = 0;
      timer_cnt = 0;
      rewind_if_empty();
   endfunction

   function automatic int find_held(logic [15:0] id, int num);
      for (int i = 0; i < FRAG_SLOTS; i++)
         if (sl_st[i] == SL_HELD && sl_id[i] == id && sl_num[i] == num) return i;
      return -1;
   endfunction

   function automatic status_type check_message(logic [15:0] id, output int mlen);
      int idx[256];
      int n, cnt, total, off, f1, a, seq, s;
      logic [31:0] dw;
      bit found_last;
      cnt = 0; total = 0; found_last = 0; mlen = 0;
      for (n = 1; n < 256; n++) begin
         s = find_held(id, n);
         if (s < 0) return RES_WAIT;
         idx[cnt++] = s;
         if (sl_last[s]) begin
            found_last = 1;
            break;
         end
      end
      if (!found_last) return RES_WAIT;
      for (int k = 0; k < cnt; k++) total += sl_len[idx[k]];
      f1 = idx[0];
      off = cfg_natt ? LEN_OFF_NATT : LEN_OFF;
      dw = '1;
      if (sl_len[f1] >= off + 4) begin
         a = sl_start[f1] + off;
         dw = {store_mem[a], store_mem[a+1], store_mem[a+2], store_mem[a+3]};
         if (cfg_natt) dw += 4;
      end
      if (sl_len[f1] < off + 4 || dw != 32'(total)) begin
         for (int k = 0; k < cnt; k++) sl_st[idx[k]] = SL_FREE;
         rewind_if_empty();
         return RES_FAIL;
      end
      free_state(SL_READ);
      seq = 0;
      for (int k = 0; k < cnt; k++) begin
         if (sl_len[idx[k]] == 0) sl_st[idx[k]] = SL_FREE;
         else begin
            sl_st[idx[k]] = SL_READ;
            sl_num[idx[k]] = seq++ % 256;
         end
      end
      rd_slot = 0; rd_cursor = 0; rd_left = total;
      active = 0; timer_cnt = 0;
      rewind_if_empty();
      mlen = total;
      return RES_DONE;
   endfunction

   function automatic result_t reassemble(word_t w);
      result_t r;
      int plen, fs, hit, mlen, a, found;
      r.status = RES_NONE; r.out_byte = 0; r.out_last = 0; r.msg_len = 0;
      mlen = 0;
      case (w.kind)
         KIND_HDR: begin
            drop_receiving();
            if (!cfg_en) r.status = RES_OFF;
            else begin
               if (!active) begin
                  active = 1; timer_cnt = 0;
                  free_state(SL_HELD);
                  rewind_if_empty();
               end
               if (w.hlen < HDR_BYTES) r.status = RES_BAD;
               else begin
                  plen = int'(w.hlen) - HDR_BYTES + ((cfg_natt && w.num == 1) ? NATT_PREFIX : 0);
                  fs = FRAG_SLOTS;
                  for (int i = 0; i < FRAG_SLOTS; i++)
                     if (sl_st[i] == SL_FREE) begin
                        fs = i;
                        break;
                     end
                  hit = find_held(w.id, w.num);
                  if (hit >= 0 || fs >= FRAG_SLOTS || fill_ptr + plen > STORE_BYTES) begin
                     r.status = (hit >= 0) ? RES_DUP : RES_FULL;
                     if (plen > 0) begin
                        rx_mode = RX_SKIP; remain = plen;
                     end
                  end else begin
                     sl_id[fs] = w.id; sl_num[fs] = w.num; sl_last[fs] = w.last;
                     sl_start[fs] = fill_ptr; sl_len[fs] = plen;
                     fill_ptr += plen;
                     if (plen == 0) begin
                        sl_st[fs] = SL_HELD;
                        r.status = check_message(w.id, mlen);
                     end else begin
                        sl_st[fs] = SL_RECV;
                        rx_mode = RX_STORE; rx_slot = fs; remain = plen;
                        r.status = RES_WAIT;
                     end
                  end
               end
            end
         end
         KIND_BYTE: begin
            if (rx_mode == RX_STORE && remain > 0) begin
               a = sl_start[rx_slot] + sl_len[rx_slot] - remain;
               if (a < STORE_BYTES) store_mem[a] = w.db;
               remain--;
               if (remain == 0) begin
                  rx_mode = RX_IDLE;
                  sl_st[rx_slot] = SL_HELD;
                  r.status = check_message(sl_id[rx_slot], mlen);
               end
            end else if (rx_mode == RX_SKIP && remain > 0) begin
               remain--;
               if (remain == 0) rx_mode = RX_IDLE;
            end
         end
         KIND_TICK: begin
            if (active) begin
               if (timer_cnt < 255) timer_cnt++;
               if (timer_cnt >= cfg_tout) begin
                  flush_fragments();
                  r.status = RES_FLUSHED;
               end
            end
         end
         KIND_FLUSH: begin
            flush_fragments();
            r.status = RES_FLUSHED;
         end
         KIND_READ: begin
            if (rd_left > 0) begin
               found = FRAG_SLOTS;
               for (int i = 0; i < FRAG_SLOTS; i++)
                  if (sl_st[i] == SL_READ && sl_num[i] == rd_slot) begin
                     found = i;
                     break;
                  end
               if (found >= FRAG_SLOTS) begin
                  rd_left = 0;
                  free_state(SL_READ);
                  rewind_if_empty();
               end else begin
                  a = sl_start[found] + rd_cursor;
                  r.out_byte = (a < STORE_BYTES) ? store_mem[a] : 8'h00;
                  rd_cursor++; rd_left--;
                  if (rd_cursor >= sl_len[found]) begin
                     sl_st[found] = SL_FREE;
                     rd_slot++; rd_cursor = 0;
                  end
                  if (rd_left == 0) begin
                     r.out_last = 1;
                     free_state(SL_READ);
                     rd_slot = 0; rd_cursor = 0;
                  end
                  rewind_if_empty();
                  r.status = RES_BYTE;
               end
            end
         end
         default: ;
      endcase
      r.msg_len = 14'(mlen);
      return r;
   endfunction

   // ---------------- driver ----------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      word_t w;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            w.kind = req_kind; w.id = req_frag_id; w.num = req_frag_num;
            w.last = req_last_fragment; w.hlen = req_hdr_length; w.db = req_data_byte;
            expected_results.push_back(reassemble(w));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending.size() > 0) begin
               w = pending.pop_front();
               req_kind <= w.kind; req_frag_id <= w.id; req_frag_num <= w.num;
               req_last_fragment <= w.last; req_hdr_length <= w.hlen;
               req_data_byte <= w.db;
               req_valid <= 1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   int stall_pct = 0;

   always @(posedge clock) begin
      result_t e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("[fragment_reassembly_engine_unit] ERROR");
         $finish;
      end
      if (cycles % 300 == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
         endcase
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         checked++;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("unexpected word: status %0d byte %0h", rsp_status, rsp_out_byte);
         end else begin
            e = expected_results.pop_front();
            if (e.status == RES_DONE) completions++;
            if (rsp_status !== e.status || rsp_out_byte !== e.out_byte ||
                rsp_out_last !== e.out_last || rsp_message_length !== e.msg_len) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("mismatch @%0d: exp st %0d b %0h l %0b len %0d, got st %0d b %0h l %0b len %0d",
                           checked, e.status, e.out_byte, e.out_last, e.msg_len,
                           rsp_status, rsp_out_byte, rsp_out_last, rsp_message_length);
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_word(logic [2:0] k, logic [15:0] id, logic [7:0] num, logic last,
                            logic [15:0] hlen, logic [7:0] db);
      word_t w;
      w.kind = k; w.id = id; w.num = num; w.last = last; w.hlen = hlen; w.db = db;
      pending.push_back(w);
      words_queued++;
   endtask

   task automatic push_bytes(int n);
      for (int i = 0; i < n; i++)
         push_word(KIND_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic push_message(bit natt, bit corrupt);
      int nf, off, total, pos;
      int plen[4];
      int order[4];
      logic [7:0] msg[$];
      logic [31:0] field;
      logic [15:0] id;
      int t, j, f;
      nf = $urandom_range(1, 4);
      off = natt ? LEN_OFF_NATT : LEN_OFF;
      id = $urandom;
      total = 0;
      for (int k = 0; k < nf; k++) begin
         plen[k] = (k == 0) ? $urandom_range(off + 4, off + 24) : $urandom_range(0, 24);
         if (k == 0 && $urandom_range(0, 15) == 0) plen[k] = $urandom_range(natt ? 4 : 0, off + 3);
         total += plen[k];
         order[k] = k;
      end
      for (int i = 0; i < total; i++) msg.push_back($urandom);
      field = natt ? total - 4 : total;
      if (corrupt) field ^= 32'(1 << $urandom_range(0, 31));
      if (plen[0] >= off + 4)
         for (int i = 0; i < 4; i++) msg[off + i] = field[31 - 8*i -: 8];
      if ($urandom_range(0, 2) == 0)
         for (int k = 0; k < nf; k++) begin
            j = $urandom_range(0, nf - 1);
            t = order[k]; order[k] = order[j]; order[j] = t;
         end
      for (int k = 0; k < nf; k++) begin
         f = order[k];
         pos = 0;
         for (int i = 0; i < f; i++) pos += plen[i];
         for (int rep = 0; rep < (($urandom_range(0, 9) == 0) ? 2 : 1); rep++) begin
            push_word(KIND_HDR, id, f + 1, f == nf - 1,
                      plen[f] + HDR_BYTES - ((natt && f == 0) ? NATT_PREFIX : 0), $urandom);
            for (int i = 0; i < plen[f]; i++)
               push_word(KIND_BYTE, $urandom, $urandom, $urandom, $urandom, msg[pos + i]);
         end
         if ($urandom_range(0, 7) == 0) push_word(KIND_TICK, $urandom, $urandom, 0, 0, 0);
      end
      for (int i = 0; i < total + $urandom_range(0, 2); i++)
         push_word(KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic push_noise();
      logic [2:0] k;
      k = $urandom_range(0, 7);
      if (k == KIND_HDR) begin
         push_word(k, $urandom, $urandom, $urandom,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                   $urandom);
         push_bytes($urandom_range(0, 12));
      end else
         push_word(k, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic wait_idle();
      while (pending.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= CSR_AW'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_FRAG_ENABLED:    cfg_en = val[0];
         REG_NATT_MODE:       cfg_natt = val[0];
         REG_TIMEOUT_SECONDS: cfg_tout = val[7:0];
         default: ;
      endcase
   endtask

   task automatic random_phase(int n_words);
      int goal;
      goal = words_queued + n_words;
      while (words_queued < goal) begin
         case ($urandom_range(0, 9))
            0, 1: push_noise();
            2: push_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
            3: push_message(cfg_natt, 1);
            default: push_message(cfg_natt, 0);
         endcase
      end
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed corners
      push_word(KIND_READ, 0, 0, 0, 0, 0);
      push_word(KIND_TICK, 0, 0, 0, 0, 0);
      push_word(KIND_BYTE, 16'hFFFF, 8'hFF, 1, 16'hFFFF, 8'hFF);
      push_word(3'd5, 0, 0, 0, 0, 0);
      push_word(3'd6, 0, 0, 0, 0, 0);
      push_word(3'd7, 16'hFFFF, 8'hFF, 1, 16'hFFFF, 8'hFF);
      push_word(KIND_HDR, 16'h0000, 8'd1, 0, 16'd7, 0);
      push_bytes(2);
      push_word(KIND_HDR, 16'hFFFF, 8'd255, 1, 16'd8, 0);
      push_word(KIND_HDR, 16'hFFFF, 8'd255, 1, 16'd8, 0);
      push_word(KIND_HDR, 16'h1234, 8'd0, 1, 16'd12, 0);
      push_bytes(2);
      push_word(KIND_HDR, 16'h1234, 8'd2, 0, 16'hFFFF, 0);
      push_bytes(3);
      push_word(KIND_HDR, 16'h0042, 8'd1, 1, 16'd10, 0);
      push_bytes(2);
      push_word(KIND_FLUSH, 0, 0, 0, 0, 0);
      push_message(0, 0);
      wait_idle();

      random_phase(250);
      wait_idle();

      csr_write(REG_NATT_MODE, 1);
      csr_write(REG_TIMEOUT_SECONDS, 255);
      push_message(1, 0);
      random_phase(200);
      wait_idle();

      csr_write(REG_NATT_MODE, 0);
      csr_write(REG_TIMEOUT_SECONDS, 1);
      random_phase(150);
      wait_idle();

      csr_write(REG_FRAG_ENABLED, 0);
      random_phase(60);
      wait_idle();

      csr_write(REG_FRAG_ENABLED, 1);
      csr_write(REG_NATT_MODE, 1);
      csr_write(REG_TIMEOUT_SECONDS, 3);
      random_phase(170);
      wait_idle();

      $display("checked %0d result words, %0d messages reassembled, %0d mismatches",
               checked, completions, errors);
      if (errors == 0 && expected_results.size() == 0)
         $display("[fragment_reassembly_engine_unit] OK");
      else
         $display("[fragment_reassembly_engine_unit] ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/fre_pkg.sv
rtl/core/fre_datapath.sv
rtl/core/fre_control.sv
rtl/core/fragment_reassembly_engine_unit.sv
bench/fragment_reassembly_engine_unit_tb.sv
